// ===== design/gri_pkg.sv =====
// shared types, constants and microprogram of the gyro rate integrator
package gri_pkg;

  // port widths
  localparam int IN_W       = 112;
  localparam int OUT_W      = 208;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // truncating divisions are shifts by these amounts
  localparam int SH_ANGLE   = 12;
  localparam int SH_COUPLE  = 11;
  localparam int SH_COUNTER = 9;

  // gain reset values
  localparam logic [7:0] GAIN_RST  = 8'd11;
  localparam logic [8:0] CGAIN_RST = 9'd64;

  // program length and step counter
  localparam int NUM_STEPS = 39;
  localparam int PC_W      = $clog2(NUM_STEPS);
  typedef logic [PC_W-1:0] pc_t;
  localparam pc_t LAST_STEP = PC_W'(NUM_STEPS - 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFF_ROLL   = 3'd0,
    CFG_OFF_PITCH  = 3'd1,
    CFG_OFF_YAW    = 3'd2,
    CFG_GAIN       = 3'd3,
    CFG_CGAIN      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] off_roll;
    logic signed [15:0] off_pitch;
    logic signed [15:0] off_yaw;
    logic        [7:0]  gain;
    logic        [8:0]  cgain;
  } cfg_t;

  // input beat, highest field first so the struct maps straight onto tdata
  typedef struct packed {
    logic signed [31:0] correction_pitch;
    logic signed [31:0] correction_roll;
    logic signed [15:0] raw_yaw;
    logic signed [15:0] raw_pitch;
    logic signed [15:0] raw_roll;
  } in_t;

  // output beat, highest field first so the struct maps straight onto tdata
  typedef struct packed {
    logic signed [31:0] fixed_angle_pitch;
    logic signed [31:0] fixed_angle_roll;
    logic signed [31:0] angle_yaw;
    logic signed [31:0] raw_angle_pitch;
    logic signed [31:0] raw_angle_roll;
    logic signed [15:0] net_yaw;
    logic signed [15:0] net_pitch;
    logic signed [15:0] net_roll;
  } res_t;

  // datapath operations on the accumulator
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_WRAP16,
    OP_DIV_ANGLE,
    OP_DIV_COUPLE,
    OP_DIV_COUNTER
  } op_t;

  // operand sources
  typedef enum logic [4:0] {
    SRC_ZERO,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_NY,
    SRC_NR,
    SRC_NP,
    SRC_IN_RR,
    SRC_IN_RP,
    SRC_IN_RY,
    SRC_CORR_R,
    SRC_CORR_P,
    SRC_OFF_R,
    SRC_OFF_P,
    SRC_OFF_Y,
    SRC_GAIN,
    SRC_CGAIN,
    SRC_RAW_R,
    SRC_RAW_P,
    SRC_SUM_Y,
    SRC_FIX_R,
    SRC_FIX_P
  } src_t;

  // result destinations besides the accumulator
  typedef enum logic [3:0] {
    DST_NONE,
    DST_T0,
    DST_T1,
    DST_T2,
    DST_NY,
    DST_NR,
    DST_NP,
    DST_RAW_R,
    DST_RAW_P,
    DST_SUM_Y,
    DST_FIX_R,
    DST_FIX_P
  } dst_t;

  // sequencing: next step, hold for an input beat, emit and jump, jump
  typedef enum logic [1:0] {
    J_NEXT,
    J_WAIT_IN,
    J_EMIT,
    J_GOTO
  } jmode_t;

  typedef struct packed {
    op_t    op;
    src_t   src;
    dst_t   dst;
    jmode_t jmode;
    pc_t    jaddr;
  } ctl_t;

  // plain datapath step that falls through to the next one
  function automatic ctl_t uop(op_t op, src_t src, dst_t dst);
    ctl_t c;
    c.op    = op;
    c.src   = src;
    c.dst   = dst;
    c.jmode = J_NEXT;
    c.jaddr = '0;
    return c;
  endfunction

  // sequencing-only step
  function automatic ctl_t jmp(jmode_t jmode, pc_t jaddr);
    ctl_t c;
    c.op    = OP_NOP;
    c.src   = SRC_ZERO;
    c.dst   = DST_NONE;
    c.jmode = jmode;
    c.jaddr = jaddr;
    return c;
  endfunction

  // microprogram: one sample per pass
  function automatic ctl_t prog_rom(pc_t pc);
    ctl_t c;
    unique case (int'(pc))
      // wait for a sample
      0:  c = jmp(J_WAIT_IN, '0);
      // net yaw and yaw integral
      1:  c = uop(OP_LOAD,        SRC_IN_RY,  DST_NONE);
      2:  c = uop(OP_SUB,         SRC_OFF_Y,  DST_NONE);
      3:  c = uop(OP_WRAP16,      SRC_ZERO,   DST_NY);
      4:  c = uop(OP_ADD,         SRC_SUM_Y,  DST_SUM_Y);
      // pitch coupling term from the old corrected pitch integral
      5:  c = uop(OP_LOAD,        SRC_FIX_P,  DST_NONE);
      6:  c = uop(OP_DIV_ANGLE,   SRC_ZERO,   DST_NONE);
      7:  c = uop(OP_MUL,         SRC_NY,     DST_NONE);
      8:  c = uop(OP_MUL,         SRC_GAIN,   DST_NONE);
      9:  c = uop(OP_DIV_COUPLE,  SRC_ZERO,   DST_T0);
      // roll coupling term and its counter-coupling
      10: c = uop(OP_LOAD,        SRC_FIX_R,  DST_NONE);
      11: c = uop(OP_DIV_ANGLE,   SRC_ZERO,   DST_NONE);
      12: c = uop(OP_MUL,         SRC_NY,     DST_NONE);
      13: c = uop(OP_MUL,         SRC_GAIN,   DST_NONE);
      14: c = uop(OP_DIV_COUPLE,  SRC_ZERO,   DST_T1);
      15: c = uop(OP_MUL,         SRC_CGAIN,  DST_NONE);
      16: c = uop(OP_DIV_COUNTER, SRC_ZERO,   DST_T2);
      // net roll and roll integrals
      17: c = uop(OP_LOAD,        SRC_IN_RR,  DST_NONE);
      18: c = uop(OP_SUB,         SRC_OFF_R,  DST_NONE);
      19: c = uop(OP_ADD,         SRC_T0,     DST_NONE);
      20: c = uop(OP_ADD,         SRC_T2,     DST_NONE);
      21: c = uop(OP_WRAP16,      SRC_ZERO,   DST_NR);
      22: c = uop(OP_ADD,         SRC_RAW_R,  DST_RAW_R);
      23: c = uop(OP_LOAD,        SRC_NR,     DST_NONE);
      24: c = uop(OP_SUB,         SRC_CORR_R, DST_NONE);
      25: c = uop(OP_ADD,         SRC_FIX_R,  DST_FIX_R);
      // counter-coupling of the pitch term
      26: c = uop(OP_LOAD,        SRC_T0,     DST_NONE);
      27: c = uop(OP_MUL,         SRC_CGAIN,  DST_NONE);
      28: c = uop(OP_DIV_COUNTER, SRC_ZERO,   DST_T2);
      // net pitch and pitch integrals
      29: c = uop(OP_LOAD,        SRC_IN_RP,  DST_NONE);
      30: c = uop(OP_SUB,         SRC_OFF_P,  DST_NONE);
      31: c = uop(OP_SUB,         SRC_T1,     DST_NONE);
      32: c = uop(OP_SUB,         SRC_T2,     DST_NONE);
      33: c = uop(OP_WRAP16,      SRC_ZERO,   DST_NP);
      34: c = uop(OP_ADD,         SRC_RAW_P,  DST_RAW_P);
      35: c = uop(OP_LOAD,        SRC_NP,     DST_NONE);
      36: c = uop(OP_SUB,         SRC_CORR_P, DST_NONE);
      37: c = uop(OP_ADD,         SRC_FIX_P,  DST_FIX_P);
      // hand the result to the output register and start over
      38: c = jmp(J_EMIT, '0);
      default: c = jmp(J_GOTO, '0);
    endcase
    return c;
  endfunction

endpackage

// ===== design/gri_seq.sv =====
// microprogram sequencer: step counter, control store and jump logic
module gri_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          out_free,
  output logic          s_tready,
  output logic          take,
  output logic          emit,
  output gri_pkg::ctl_t ctl
);
  import gri_pkg::*;

  pc_t pc;
  pc_t pc_next;

  // control word of the current step, no beat is taken during reset
  assign ctl      = prog_rom(pc);
  assign s_tready = !rst && (ctl.jmode == J_WAIT_IN);
  assign take     = s_tready && s_tvalid;
  assign emit     = (ctl.jmode == J_EMIT) && out_free;

  // next step
  always_comb begin
    unique case (ctl.jmode)
      J_NEXT:    pc_next = pc + 1'b1;
      J_WAIT_IN: pc_next = take ? pc + 1'b1 : pc;
      J_EMIT:    pc_next = out_free ? ctl.jaddr : pc;
      J_GOTO:    pc_next = ctl.jaddr;
      default:   pc_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  // accepted beat starts the program body
  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    take |=> (pc == PC_W'(1)))
    else $error("sample accepted but program did not advance to its first step");

  // an emitted result always returns to the wait step
  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    emit |=> (pc == '0))
    else $error("emit did not return to the wait step");

  // step counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= LAST_STEP)
    else $error("step counter left the program");

endmodule

// ===== design/gri_dp.sv =====
// accumulator datapath with operand mux, multiplier and integral registers
module gri_dp (
  input  logic          clk,
  input  logic          rst,
  input  gri_pkg::ctl_t ctl,
  input  logic          take,
  input  gri_pkg::in_t  in_item,
  input  gri_pkg::cfg_t cfg,
  output gri_pkg::res_t res
);
  import gri_pkg::*;

  // signed divide by a power of two, rounding toward zero
  function automatic logic signed [31:0] sdiv_pow2(logic signed [31:0] x, int sh);
    logic signed [31:0] bias;
    bias = x[31] ? ((32'sd1 <<< sh) - 32'sd1) : 32'sd0;
    return (x + bias) >>> sh;
  endfunction

  in_t                in_q;
  logic signed [31:0] acc;
  logic signed [31:0] t0;
  logic signed [31:0] t1;
  logic signed [31:0] t2;
  logic signed [15:0] ny;
  logic signed [15:0] nr;
  logic signed [15:0] np;
  logic signed [31:0] raw_r;
  logic signed [31:0] raw_p;
  logic signed [31:0] sum_y;
  logic signed [31:0] fix_r;
  logic signed [31:0] fix_p;

  logic signed [31:0] src_val;
  logic signed [31:0] prod;
  logic signed [31:0] alu;

  // operand select
  always_comb begin
    unique case (ctl.src)
      SRC_ZERO:   src_val = '0;
      SRC_T0:     src_val = t0;
      SRC_T1:     src_val = t1;
      SRC_T2:     src_val = t2;
      SRC_NY:     src_val = 32'(ny);
      SRC_NR:     src_val = 32'(nr);
      SRC_NP:     src_val = 32'(np);
      SRC_IN_RR:  src_val = 32'(in_q.raw_roll);
      SRC_IN_RP:  src_val = 32'(in_q.raw_pitch);
      SRC_IN_RY:  src_val = 32'(in_q.raw_yaw);
      SRC_CORR_R: src_val = in_q.correction_roll;
      SRC_CORR_P: src_val = in_q.correction_pitch;
      SRC_OFF_R:  src_val = 32'(cfg.off_roll);
      SRC_OFF_P:  src_val = 32'(cfg.off_pitch);
      SRC_OFF_Y:  src_val = 32'(cfg.off_yaw);
      SRC_GAIN:   src_val = {24'd0, cfg.gain};
      SRC_CGAIN:  src_val = {23'd0, cfg.cgain};
      SRC_RAW_R:  src_val = raw_r;
      SRC_RAW_P:  src_val = raw_p;
      SRC_SUM_Y:  src_val = sum_y;
      SRC_FIX_R:  src_val = fix_r;
      SRC_FIX_P:  src_val = fix_p;
      default:    src_val = '0;
    endcase
  end

  // low 32 bits of the product, wraps like the integrals
  assign prod = acc * src_val;

  // accumulator operation
  always_comb begin
    unique case (ctl.op)
      OP_NOP:         alu = acc;
      OP_LOAD:        alu = src_val;
      OP_ADD:         alu = acc + src_val;
      OP_SUB:         alu = acc - src_val;
      OP_MUL:         alu = prod;
      OP_WRAP16:      alu = {{16{acc[15]}}, acc[15:0]};
      OP_DIV_ANGLE:   alu = sdiv_pow2(acc, SH_ANGLE);
      OP_DIV_COUPLE:  alu = sdiv_pow2(acc, SH_COUPLE);
      OP_DIV_COUNTER: alu = sdiv_pow2(acc, SH_COUNTER);
      default:        alu = acc;
    endcase
  end

  // sample capture, accumulator and scratch registers
  always_ff @(posedge clk) begin
    if (take) begin
      in_q <= in_item;
    end
    if (ctl.op != OP_NOP) begin
      acc <= alu;
    end
    unique case (ctl.dst)
      DST_T0:  t0 <= alu;
      DST_T1:  t1 <= alu;
      DST_T2:  t2 <= alu;
      DST_NY:  ny <= alu[15:0];
      DST_NR:  nr <= alu[15:0];
      DST_NP:  np <= alu[15:0];
      default: ;
    endcase
  end

  // integrals
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_r <= '0;
      raw_p <= '0;
      sum_y <= '0;
      fix_r <= '0;
      fix_p <= '0;
    end else begin
      unique case (ctl.dst)
        DST_RAW_R: raw_r <= alu;
        DST_RAW_P: raw_p <= alu;
        DST_SUM_Y: sum_y <= alu;
        DST_FIX_R: fix_r <= alu;
        DST_FIX_P: fix_p <= alu;
        default:   ;
      endcase
    end
  end

  // result fields
  always_comb begin
    res.net_roll          = nr;
    res.net_pitch         = np;
    res.net_yaw           = ny;
    res.raw_angle_roll    = raw_r;
    res.raw_angle_pitch   = raw_p;
    res.angle_yaw         = sum_y;
    res.fixed_angle_roll  = fix_r;
    res.fixed_angle_pitch = fix_p;
  end

endmodule

// ===== design/gyro_rate_integrator_axis_coupling.sv =====
// top level: gyro rate integrator with yaw cross-coupling
//
// One input beat carries a three-axis gyro sample and the roll and pitch
// attitude corrections; one output beat follows with the net rates and all
// five integrals after the update. Both sides are tvalid/tready streams.
// The user must write offsets and coupling gains through the cfg port only
// while the block is idle; the block itself does not enforce this. Each
// write lands at the clock edge with cfg_we high. A microprogram of 39
// steps runs the arithmetic on a shared accumulator datapath with one 32x32
// multiplier: the wait step takes a beat, 37 steps compute, and the emit
// step loads the output register. A new beat is thus accepted only after
// the previous result has gone to the output register.
// The output register parts the two sides: the next beat is accepted while
// a finished result still waits. If the receiver stalls, the emit step holds
// until the output register is free, and input acceptance pauses with it.
// Synchronous reset clears the integrals, loads the offsets with zero and
// the gains with 11 and 64, and empties the output register; s_tready stays
// low while reset is high.
module gyro_rate_integrator_axis_coupling (
  input  logic                           clk,
  input  logic                           rst,
  // raw_roll, raw_pitch, raw_yaw, correction_roll, correction_pitch
  input  logic [gri_pkg::IN_W-1:0]       s_tdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // net_roll, net_pitch, net_yaw, raw_angle_roll, raw_angle_pitch,
  // angle_yaw, fixed_angle_roll, fixed_angle_pitch
  output logic [gri_pkg::OUT_W-1:0]      m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_we,
  input  logic [gri_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gri_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gri_pkg::*;

  cfg_t cfg;
  ctl_t ctl;
  res_t res;
  logic take;
  logic emit;
  logic out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.off_roll  <= '0;
      cfg.off_pitch <= '0;
      cfg.off_yaw   <= '0;
      cfg.gain      <= GAIN_RST;
      cfg.cgain     <= CGAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFF_ROLL:  cfg.off_roll  <= cfg_data;
        CFG_OFF_PITCH: cfg.off_pitch <= cfg_data;
        CFG_OFF_YAW:   cfg.off_yaw   <= cfg_data;
        CFG_GAIN:      cfg.gain      <= cfg_data[7:0];
        CFG_CGAIN:     cfg.cgain     <= cfg_data[8:0];
        default:       ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;

  gri_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .out_free (out_free),
    .s_tready (s_tready),
    .take     (take),
    .emit     (emit),
    .ctl      (ctl)
  );

  gri_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .take    (take),
    .in_item (in_t'(s_tdata)),
    .cfg     (cfg),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= OUT_W'(res);
    end
  end

  // a taken beat with nothing new behind it empties the output register
  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !emit) |=> !m_tvalid)
    else $error("output beat taken but output register stayed full");

endmodule

// ===== sim/tb_top.sv =====
// testbench for the gyro rate integrator: directed and random samples checked against a predictor
module tb_top;
  import gri_pkg::*;

  localparam int LONG_HOLD       = 400;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 100;
  localparam int DRAIN_CYCLES    = 2 * NUM_STEPS;
  localparam int CFG_SPARE_FIRST = int'(CFG_CGAIN) + 1;
  localparam int CFG_SPARE_LAST  = (1 << CFG_IDX_W) - 1;

  localparam logic signed [15:0] R_MAX = 16'sh7FFF;
  localparam logic signed [15:0] R_MIN = 16'sh8000;
  localparam logic signed [31:0] C_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] C_MIN = 32'sh80000000;

  typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

  // predicted integrals and the results still owed by the block
  class rate_integral_model;
    logic signed [15:0] off_roll, off_pitch, off_yaw;
    logic [7:0] gain;
    logic [8:0] cgain;
    int raw_roll_sum, raw_pitch_sum, yaw_sum, fix_roll_sum, fix_pitch_sum;
    res_t pending_results[$];
    int errors;
    int checked;

    function new();
      off_roll = '0;
      off_pitch = '0;
      off_yaw = '0;
      gain = GAIN_RST;
      cgain = CGAIN_RST;
      raw_roll_sum = 0;
      raw_pitch_sum = 0;
      yaw_sum = 0;
      fix_roll_sum = 0;
      fix_pitch_sum = 0;
      errors = 0;
      checked = 0;
    endfunction

    // spare indexes fall through, wide data keeps only the low bits
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_OFF_ROLL:  off_roll = data;
        CFG_OFF_PITCH: off_pitch = data;
        CFG_OFF_YAW:   off_yaw = data;
        CFG_GAIN:      gain = data[7:0];
        CFG_CGAIN:     cgain = data[8:0];
        default: ;
      endcase
    endfunction

    // integral/4096 times net yaw times gain, wrapped at 32 bits, then /2048
    function int couple_term(int integral, int ny);
      int p;
      p = (integral / (1 << SH_ANGLE)) * ny;
      p = p * int'(gain);
      return p / (1 << SH_COUPLE);
    endfunction

    function void note_sample(in_t s);
      shortint ny, nr, np;
      int cp, cr;
      res_t r;
      ny = s.raw_yaw - off_yaw;
      nr = s.raw_roll - off_roll;
      np = s.raw_pitch - off_pitch;
      yaw_sum += ny;
      // both terms use the corrected integrals from before this sample
      cp = couple_term(fix_pitch_sum, ny);
      cr = couple_term(fix_roll_sum, ny);
      nr = 16'(nr + cp);
      nr = 16'(nr + (cr * int'(cgain)) / (1 << SH_COUNTER));
      np = 16'(np - cr);
      np = 16'(np - (cp * int'(cgain)) / (1 << SH_COUNTER));
      raw_roll_sum += nr;
      fix_roll_sum += nr - s.correction_roll;
      raw_pitch_sum += np;
      fix_pitch_sum += np - s.correction_pitch;
      r.net_roll = nr;
      r.net_pitch = np;
      r.net_yaw = ny;
      r.raw_angle_roll = raw_roll_sum;
      r.raw_angle_pitch = raw_pitch_sum;
      r.angle_yaw = yaw_sum;
      r.fixed_angle_roll = fix_roll_sum;
      r.fixed_angle_pitch = fix_pitch_sum;
      pending_results.push_back(r);
    endfunction

    function void compare(string field, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_beat(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("output beat with no sample outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare("net_roll", want.net_roll, got.net_roll);
      compare("net_pitch", want.net_pitch, got.net_pitch);
      compare("net_yaw", want.net_yaw, got.net_yaw);
      compare("raw_angle_roll", want.raw_angle_roll, got.raw_angle_roll);
      compare("raw_angle_pitch", want.raw_angle_pitch, got.raw_angle_pitch);
      compare("angle_yaw", want.angle_yaw, got.angle_yaw);
      compare("fixed_angle_roll", want.fixed_angle_roll, got.fixed_angle_roll);
      compare("fixed_angle_pitch", want.fixed_angle_pitch, got.fixed_angle_pitch);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [OUT_W-1:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rate_integral_model integ = new();

  bit gaps_on = 1'b1;
  int burst_left = 0;
  int holds_asked = 0;

  gyro_rate_integrator_axis_coupling DUT (.*);

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hard limit on the run
  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // check every accepted output beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) integ.check_beat(m_tdata);
  end

  // receiver: changing stall patterns plus long hold-offs on request
  initial begin
    int mode_left, hold_left, holds_seen;
    rx_mode_t mode;
    mode_left = 0;
    hold_left = 0;
    holds_seen = 0;
    mode = RX_OPEN;
    forever begin
      @(negedge clk);
      if (holds_seen != holds_asked) begin
        holds_seen = holds_asked;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(5, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_RANDOM: m_tready <= ($urandom_range(0, 1) == 1);
          default:   m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic in_t sample(logic signed [15:0] rr, logic signed [15:0] rp,
                                 logic signed [15:0] ry, logic signed [31:0] cr,
                                 logic signed [31:0] cp);
    in_t s;
    s.raw_roll = rr;
    s.raw_pitch = rp;
    s.raw_yaw = ry;
    s.correction_roll = cr;
    s.correction_pitch = cp;
    return s;
  endfunction

  // one register write, called at a falling edge
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    integ.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // offer one sample, with burst gaps, until the block takes it
  task automatic send_sample(in_t smp);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      s_tdata <= IN_W'({$urandom, $urandom, $urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    do @(posedge clk); while (!s_tready);
    integ.note_sample(smp);
    @(negedge clk);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (integ.pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    in_t smp;
    logic [CFG_DATA_W-1:0] data;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset offsets and gains, extremes of the samples
    send_sample(sample(0, 0, 0, 0, 0));
    send_sample(sample(R_MAX, R_MAX, R_MAX, 0, 0));
    send_sample(sample(R_MIN, R_MIN, R_MIN, C_MAX, C_MAX));
    send_sample(sample(0, 0, R_MAX, C_MIN, C_MIN));
    send_sample(sample(0, 0, R_MAX, 0, 0));
    send_sample(sample(0, 0, R_MIN, 0, 0));
    drain();

    // lowest offsets, oversized gain data, writes to spare indexes
    cfg_write(CFG_OFF_ROLL, R_MIN);
    cfg_write(CFG_OFF_PITCH, R_MIN);
    cfg_write(CFG_OFF_YAW, R_MIN);
    cfg_write(CFG_GAIN, 16'hFFFF);
    cfg_write(CFG_CGAIN, 16'hFFFF);
    for (int i = CFG_SPARE_FIRST; i <= CFG_SPARE_LAST; i++)
      cfg_write(CFG_IDX_W'(i), 16'hFFFF);
    send_sample(sample(R_MAX, R_MAX, R_MAX, C_MIN, C_MAX));
    send_sample(sample(R_MIN, R_MIN, R_MIN, C_MAX, C_MIN));
    send_sample(sample(R_MAX, R_MIN, R_MAX, 0, 0));
    send_sample(sample(0, 0, R_MIN, C_MIN, C_MAX));
    send_sample(sample(R_MAX, R_MAX, R_MAX, C_MAX, C_MIN));
    drain();

    // highest offsets, zero gains
    cfg_write(CFG_OFF_ROLL, R_MAX);
    cfg_write(CFG_OFF_PITCH, R_MAX);
    cfg_write(CFG_OFF_YAW, R_MAX);
    cfg_write(CFG_GAIN, 16'h0000);
    cfg_write(CFG_CGAIN, 16'h0000);
    send_sample(sample(R_MIN, R_MIN, R_MIN, 0, 0));
    send_sample(sample(R_MAX, R_MAX, R_MIN, C_MIN, C_MIN));
    send_sample(sample(0, 0, R_MAX, C_MAX, C_MAX));
    drain();

    // full gains, small negative integrals for truncation toward zero
    cfg_write(CFG_OFF_ROLL, 16'h0000);
    cfg_write(CFG_OFF_PITCH, 16'h0000);
    cfg_write(CFG_OFF_YAW, 16'h0000);
    cfg_write(CFG_GAIN, 16'h00FF);
    cfg_write(CFG_CGAIN, 16'h01FF);
    send_sample(sample(0, 0, R_MAX, 4097, 4095));
    send_sample(sample(0, 0, R_MIN, 1, -1));
    send_sample(sample(0, 0, R_MAX, C_MIN, C_MAX));
    send_sample(sample(R_MIN, R_MAX, R_MIN, -4097, 8193));
    send_sample(sample(0, 0, R_MAX, 0, 0));
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int r = int'(CFG_OFF_ROLL); r <= int'(CFG_CGAIN); r++) begin
        case ($urandom_range(0, 3))
          0:       data = 16'h8000;
          1:       data = 16'h7FFF;
          default: data = CFG_DATA_W'($urandom);
        endcase
        cfg_write(CFG_IDX_W'(r), data);
      end
      if ($urandom_range(0, 3) == 0)
        cfg_write(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                  CFG_DATA_W'($urandom));
      gaps_on = (ph != 1);
      if (ph == 3) holds_asked++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        smp.raw_roll = 16'($urandom);
        smp.raw_pitch = 16'($urandom);
        smp.raw_yaw = 16'($urandom);
        if ($urandom_range(0, 7) == 0) smp.raw_yaw = $urandom_range(0, 1) ? R_MAX : R_MIN;
        case ($urandom_range(0, 7))
          0: begin
            smp.correction_roll = $urandom_range(0, 1) ? C_MAX : C_MIN;
            smp.correction_pitch = $urandom_range(0, 1) ? C_MAX : C_MIN;
          end
          1, 2, 3: begin
            smp.correction_roll = $urandom;
            smp.correction_pitch = $urandom;
          end
          default: begin
            smp.correction_roll = int'($urandom_range(0, 8191)) - 4096;
            smp.correction_pitch = int'($urandom_range(0, 8191)) - 4096;
          end
        endcase
        send_sample(smp);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("tb_top: %0d samples checked: directed extremes, then %0d random settings",
             integ.checked, PHASES);
    $display("tb_top: bursty input, varied output stalls, one %0d-cycle output hold-off",
             LONG_HOLD);
    if (integ.errors == 0 && integ.pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/gri_pkg.sv
design/gri_seq.sv
design/gri_dp.sv
design/gyro_rate_integrator_axis_coupling.sv
sim/tb_top.sv
